>>> rtl/csr_sparse_matvec_top_defines.svh
// assertion macros for the sparse matrix-vector block
`ifndef CSR_SPARSE_MATVEC_TOP_DEFINES_SVH
`define CSR_SPARSE_MATVEC_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CSM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSM_ASSERT(label, clk, rst_n, prop, msg)
`define CSM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/csm_pkg.sv
// types, codes and double-precision helpers for the sparse matrix-vector block
`timescale 1ns / 1ps
`default_nettype none
package csm_pkg;

    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 9;
    localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_NUM_COLS = 1'b1;

    localparam logic [2:0] OP_WRITE_X = 3'd0;
    localparam logic [2:0] OP_WRITE_RANGE = 3'd1;
    localparam logic [2:0] OP_WRITE_Y = 3'd2;
    localparam logic [2:0] OP_NONZERO = 3'd3;
    localparam logic [2:0] OP_READ_Y = 3'd4;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_NO_ROW = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  index;
        logic [63:0] value;
        logic [15:0] range_first;
        logic [15:0] range_last;
        logic [15:0] nz_index;
        logic [15:0] column;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] read_value;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_LAST,
        S_FETCH,
        S_MUL,
        S_MUL_RND,
        S_ADD_ALIGN,
        S_ADD_SUM,
        S_ADD_NORM,
        S_ADD_RND,
        S_READ,
        S_OUT
    } t_state;

    // unpacked operand for the fp datapath
    typedef struct packed {
        logic        sign;
        logic        is_nan;
        logic        is_inf;
        logic        is_zero;
        logic [12:0] exp;    // unbiased-plus-bias, subnormals normalized lazily
        logic [52:0] mant;   // with hidden bit
    } t_fp_unpacked;

    localparam logic [63:0] QNAN = 64'h7FF8_0000_0000_0000;

    function automatic t_fp_unpacked fp_unpack(input logic [63:0] b);
        t_fp_unpacked u;
        u.sign = b[63];
        u.is_nan = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
        u.is_inf = (b[62:52] == 11'h7FF) && (b[51:0] == '0);
        u.is_zero = (b[62:0] == '0);
        if (b[62:52] == '0) begin
            u.exp = 13'd1;
            u.mant = {1'b0, b[51:0]};
        end else begin
            u.exp = {2'b00, b[62:52]};
            u.mant = {1'b1, b[51:0]};
        end
        return u;
    endfunction

    // round to nearest even and pack; m is 56 bits: 53 kept, guard, round, sticky
    // e is the biased exponent of m's top bit position 55 (signed)
    function automatic logic [63:0] fp_round_pack(input logic s, input logic signed [14:0] e,
                                                  input logic [55:0] m);
        logic [55:0]        mm;
        logic signed [14:0] ee;
        logic [14:0]        sh;
        logic               st;
        logic [53:0]        r;
        logic               inc;
        logic [63:0]        res;
        mm = m;
        ee = e;
        st = 1'b0;
        res = '0;
        if (ee < 15'sd1) begin
            sh = 15'(15'sd1 - ee);
            if (sh > 15'd57) begin
                st = |mm;
                mm = '0;
            end else begin
                for (int i = 0; i < 56; i++) begin
                    if (i < int'(sh)) st = st | mm[i];
                end
                mm = mm >> sh;
            end
            mm[0] = mm[0] | st;
            ee = 15'sd0;
        end
        inc = mm[2] & (mm[1] | mm[0] | mm[3]);
        r = {1'b0, mm[55:3]} + {53'd0, inc};
        if (r[53]) begin
            r = r >> 1;
            ee = ee + 15'sd1;
        end
        if (ee == 15'sd0 && r[52]) ee = 15'sd1;
        if (ee >= 15'sd2047) res = {s, 11'h7FF, 52'd0};
        else res = {s, ee[10:0], r[51:0]};
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/csr_sparse_matvec_top.sv
// sparse matrix (csr) times dense vector, double precision, memory-based
// usage:
//   input channel i_in_valid/o_in_ready carries one t_in_item per transaction;
//   output channel o_out_valid/i_out_ready returns one t_out_item per input item.
//   configuration: i_cfg_we with i_cfg_index (0 num_rows, 1 num_cols) and i_cfg_data;
//   the user writes it only while the block is idle; the block does not enforce this.
// sequencing:
//   loads and bad indexes go through S_OUT to the output register; read y first
//   passes S_READ; nonzero runs the row-range scan over all ROWS entries
//   that reads one range memory entry per cycle, then a multiply of four
//   partial products, its rounding step and a four-step add-round on y.
//   one item is in flight at a time; the next is taken once the result is
//   parked in the output register, even while the receiver stalls.
// reset:
//   synchronous active low; clears control, range valid bits and y valid bits
//   (an unwritten y entry reads as zero); x and range memories are undefined
//   until written. no clearing pass, items are taken right after reset.
// stall:
//   while o_out_valid is high and i_out_ready low, the result holds and
//   no new item is accepted after the one already in work completes.
`timescale 1ns / 1ps
`default_nettype none
`include "csr_sparse_matvec_top_defines.svh"
module csr_sparse_matvec_top
    import csm_pkg::*;
#(
    parameter int unsigned ROWS = 256,
    parameter int unsigned COLS = 256,
    parameter int unsigned NNZ_WIDTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_in_item            i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_out_item                o_out
);
    localparam int unsigned RW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned CW = (COLS > 1) ? $clog2(COLS) : 1;

    // memories
    logic [63:0]          x_mem [COLS];
    logic [63:0]          y_mem [ROWS];
    logic [NNZ_WIDTH-1:0] rf_mem [ROWS];
    logic [NNZ_WIDTH-1:0] rl_mem [ROWS];
    logic [ROWS-1:0]      r_range_valid;
    logic [ROWS-1:0]      r_y_valid;

    logic [8:0] r_num_rows;
    logic [8:0] r_num_cols;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [RW-1:0] r_scan, n_scan;
    logic [RW-1:0] r_scan_q;
    logic          r_scan_q_live;
    logic          r_found;
    logic [RW-1:0] r_row;
    logic [63:0]   x_rd, y_rd;
    logic [NNZ_WIDTH-1:0] rf_rd, rl_rd;
    logic          r_yv_q;

    logic          r_out_valid;
    t_out_item     r_out;

    // datapath registers
    logic               r_ps;
    logic signed [14:0] r_pe;
    logic [105:0]       r_pm;
    logic [1:0]         r_mcnt;
    logic               r_pspec;
    logic [63:0]        r_pspec_val;
    logic [63:0]        r_prod;
    logic [63:0]        r_ybits;
    logic               r_big_s;
    logic signed [14:0] r_ae;
    logic [57:0]        r_am_big, r_am_sml;
    logic               r_asub;
    logic [58:0]        r_sum;
    logic [63:0]        r_aspec_val;
    logic               r_aspec;
    logic [55:0]        r_nm;
    logic signed [14:0] r_ne;

    logic [RW-1:0] idx_row;
    logic [CW-1:0] idx_col;
    logic          idx_row_ok, idx_col_ok;
    logic [NNZ_WIDTH-1:0] nz_pos;
    logic          acc_in, fire_out, out_go;
    logic          col_ok;
    logic [CW-1:0] col_addr;
    logic [RW-1:0] y_addr;
    logic [63:0]   add_res;

    // match result including the last scan entry, seen in S_SCAN_LAST
    logic          r_found_next;
    logic [RW-1:0] r_row_next;
    logic          last_hit;

    assign idx_row = RW'(r_item.index);
    assign idx_col = CW'(r_item.index);
    assign idx_row_ok = 32'(r_item.index) < ROWS;
    assign idx_col_ok = 32'(r_item.index) < COLS;
    assign nz_pos = NNZ_WIDTH'(r_item.nz_index);
    assign acc_in = i_in_valid && o_in_ready;
    assign fire_out = r_out_valid && i_out_ready;
    // the finished transaction moves into the output register only when it is free
    assign out_go = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= 9'd256;
            r_num_cols <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign col_ok = (r_item.column < 16'(r_num_cols)) && (32'(r_item.column) < COLS);
    assign col_addr = CW'(r_item.column);
    // a read keeps its address while the result waits for the output register
    assign y_addr = (r_item.operation == OP_READ_Y) ? idx_row : r_row;

    // memory ports
    always_ff @(posedge i_clk) begin
        rf_rd <= rf_mem[r_scan];
        rl_rd <= rl_mem[r_scan];
        x_rd <= x_mem[col_addr];
        y_rd <= y_mem[y_addr];
        if (out_go && r_item.operation == OP_WRITE_X && idx_col_ok)
            x_mem[idx_col] <= r_item.value;
        if (out_go && r_item.operation == OP_WRITE_RANGE && idx_row_ok) begin
            rf_mem[idx_row] <= NNZ_WIDTH'(r_item.range_first);
            rl_mem[idx_row] <= NNZ_WIDTH'(r_item.range_last);
        end
        if (out_go && r_item.operation == OP_WRITE_Y && idx_row_ok)
            y_mem[idx_row] <= r_item.value;
        else if (r_state == S_ADD_RND)
            y_mem[r_row] <= add_res;
    end

    assign add_res = r_aspec ? r_aspec_val : fp_round_pack(r_big_s, r_ne, r_nm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_range_valid <= '0;
            r_y_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire_out) r_out_valid <= 1'b0;
            if (out_go) begin
                r_out_valid <= 1'b1;
                if (r_item.operation == OP_WRITE_RANGE && idx_row_ok)
                    r_range_valid[idx_row] <= 1'b1;
                if (r_item.operation == OP_WRITE_Y && idx_row_ok)
                    r_y_valid[idx_row] <= 1'b1;
            end
            if (r_state == S_ADD_RND) r_y_valid[r_row] <= 1'b1;
        end
    end

    // output result built on the way into the output register
    logic [1:0]  res_status;
    logic [63:0] res_read;
    always_comb begin
        res_status = ST_DONE;
        res_read = '0;
        case (r_item.operation)
            OP_WRITE_X: if (!idx_col_ok) res_status = ST_BAD_INDEX;
            OP_WRITE_RANGE, OP_WRITE_Y: if (!idx_row_ok) res_status = ST_BAD_INDEX;
            OP_READ_Y: begin
                if (!idx_row_ok) res_status = ST_BAD_INDEX;
                else res_read = r_yv_q ? y_rd : 64'd0;
            end
            OP_NONZERO: begin
                if (!r_found) res_status = ST_NO_ROW;
                else if (!(col_ok && 32'(r_row) < 32'(r_num_rows))) res_status = ST_SKIPPED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) r_item <= i_in;
        r_scan <= n_scan;
        r_scan_q <= r_scan;
        if (r_state == S_IDLE) r_found <= 1'b0;
        if ((r_state == S_SCAN || r_state == S_SCAN_LAST) && last_hit) begin
            r_found <= 1'b1;
            r_row <= r_scan_q;
        end
        r_yv_q <= r_y_valid[y_addr];
        if (out_go) begin
            r_out.status <= res_status;
            r_out.read_value <= res_read;
        end
    end

    // first cycle of a scan has no read data yet
    always_ff @(posedge i_clk) begin
        r_scan_q_live <= (r_state == S_SCAN);
    end

    assign last_hit = r_scan_q_live && r_range_valid[r_scan_q] && rf_rd <= nz_pos
                      && nz_pos <= rl_rd;
    assign r_found_next = r_found || last_hit;
    assign r_row_next = last_hit ? r_scan_q : r_row;

    // ---------- double multiply ----------
    // 53x53 mantissa product from four 27x27 partial products, one per cycle
    t_fp_unpacked ua, ub, uy, up;
    logic [26:0]  mul_a, mul_b;
    logic [53:0]  mul_pp;
    logic [105:0] mul_term;
    assign ua = fp_unpack(r_item.value);
    assign ub = fp_unpack(x_rd);
    always_comb begin
        mul_a = r_mcnt[0] ? {1'b0, ua.mant[52:27]} : ua.mant[26:0];
        mul_b = r_mcnt[1] ? {1'b0, ub.mant[52:27]} : ub.mant[26:0];
        mul_pp = mul_a * mul_b;
        case (r_mcnt)
            2'd0: mul_term = {52'd0, mul_pp};
            2'd3: mul_term = {mul_pp[51:0], 54'd0};
            default: mul_term = {25'd0, mul_pp, 27'd0};
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_mcnt <= r_mcnt + 2'd1;
            r_pm <= ((r_mcnt == 2'd0) ? 106'd0 : r_pm) + mul_term;
            r_ps <= ua.sign ^ ub.sign;
            r_pe <= 15'(signed'({2'b00, ua.exp})) + 15'(signed'({2'b00, ub.exp})) - 15'sd1022;
            r_pspec <= ua.is_nan || ub.is_nan || ua.is_inf || ub.is_inf
                       || ua.is_zero || ub.is_zero;
            if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero) || (ub.is_inf && ua.is_zero))
                r_pspec_val <= QNAN;
            else if (ua.is_inf || ub.is_inf)
                r_pspec_val <= {ua.sign ^ ub.sign, 11'h7FF, 52'd0};
            else
                r_pspec_val <= {ua.sign ^ ub.sign, 63'd0};
        end else begin
            r_mcnt <= 2'd0;
        end
    end

    // normalize the 106-bit product (top bit at 105 or 104 unless an operand is subnormal) and round
    logic [55:0]        pm_n;
    logic signed [14:0] pe_n;
    logic [6:0]         plz;
    logic [105:0]       pm_sh;
    always_comb begin
        plz = '0;
        for (int i = 0; i < 106; i++) begin
            if (r_pm[i]) plz = 7'(105 - i);
        end
        pm_sh = r_pm << plz;
        pe_n = r_pe - 15'(signed'({8'd0, plz}));
        pm_n = {pm_sh[105:51], |pm_sh[50:0]};
    end
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL_RND) begin
            r_prod <= r_pspec ? r_pspec_val : fp_round_pack(r_ps, pe_n, pm_n);
            r_ybits <= r_yv_q ? y_rd : 64'd0;
        end
    end

    // ---------- double add ----------
    assign uy = fp_unpack(r_ybits);
    assign up = fp_unpack(r_prod);
    logic               swap;
    logic [14:0]        ediff;
    logic [57:0]        sml_sh;
    t_fp_unpacked       ub_g, us_g;
    always_comb begin
        swap = ({up.exp, up.mant} > {uy.exp, uy.mant});
        ub_g = swap ? up : uy;
        us_g = swap ? uy : up;
        ediff = 15'({2'b00, ub_g.exp} - {2'b00, us_g.exp});
        sml_sh = '0;
        if (ediff > 15'd57) sml_sh = {57'd0, |us_g.mant};
        else begin
            sml_sh = {us_g.mant, 5'd0} >> ediff;
            for (int i = 0; i < 58; i++)
                if (i < int'(ediff) && i < 58 && us_g.mant != '0 &&
                    ((({us_g.mant, 5'd0}) >> i) & 58'd1) != '0) sml_sh[0] = 1'b1;
        end
    end

    // normalize sum: bit 58 carry; top bit wanted at 55 of 56-bit round input
    logic [6:0]  slz;
    logic [58:0] s_sh;
    logic        zero_sum;
    always_comb begin
        slz = 7'd59;
        for (int i = 0; i < 59; i++) begin
            if (r_sum[i]) slz = 7'(58 - i);
        end
        zero_sum = (r_sum == '0);
        s_sh = r_sum << slz;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD_ALIGN) begin
            r_big_s <= ub_g.sign;
            r_ae <= 15'(signed'({2'b00, ub_g.exp}));
            r_am_big <= {ub_g.mant, 5'd0};
            r_am_sml <= sml_sh;
            r_asub <= ub_g.sign ^ us_g.sign;
            r_aspec <= uy.is_nan || up.is_nan || uy.is_inf || up.is_inf
                       || (uy.is_zero && up.is_zero);
            if (uy.is_nan || up.is_nan || (uy.is_inf && up.is_inf && uy.sign != up.sign))
                r_aspec_val <= QNAN;
            else if (uy.is_inf) r_aspec_val <= r_ybits;
            else if (up.is_inf) r_aspec_val <= r_prod;
            else r_aspec_val <= {uy.sign & up.sign, 63'd0};
        end
        if (r_state == S_ADD_SUM)
            r_sum <= r_asub ? {1'b0, r_am_big} - {1'b0, r_am_sml}
                            : {1'b0, r_am_big} + {1'b0, r_am_sml};
        if (r_state == S_ADD_NORM) begin
            // value = sum * 2^(ae - 57); top at 58-slz -> exp ae + 1 - slz
            r_ne <= r_ae + 15'sd1 - 15'(signed'({8'd0, slz}));
            r_nm <= {s_sh[58:4], |s_sh[3:0]};
            if (zero_sum && !r_aspec) begin
                r_aspec <= 1'b1;
                r_aspec_val <= 64'd0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_scan = r_scan;
        unique case (r_state)
            S_IDLE: begin
                n_scan = '0;
                if (acc_in) begin
                    if (i_in.operation == OP_NONZERO) n_state = S_SCAN;
                    else if (i_in.operation == OP_READ_Y) n_state = S_READ;
                    else n_state = S_OUT;
                end
            end
            S_SCAN: begin
                if (32'(r_scan) == ROWS - 1) n_state = S_SCAN_LAST;
                else n_scan = r_scan + 1'b1;
            end
            S_SCAN_LAST: begin
                n_state = (r_found_next && col_ok && 32'(r_row_next) < 32'(r_num_rows))
                          ? S_FETCH : S_OUT;
            end
            S_FETCH: n_state = S_MUL;
            S_MUL: n_state = (r_mcnt == 2'd3) ? S_MUL_RND : S_MUL;
            S_MUL_RND: n_state = S_ADD_ALIGN;
            S_ADD_ALIGN: n_state = S_ADD_SUM;
            S_ADD_SUM: n_state = S_ADD_NORM;
            S_ADD_NORM: n_state = S_ADD_RND;
            S_ADD_RND: n_state = S_OUT;
            S_READ: n_state = S_OUT;
            S_OUT: n_state = out_go ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------- checks ----------
    `CSM_ASSERT(a_one_in_flight, i_clk, i_rst_n, acc_in |=> !o_in_ready, "item taken while busy")
    `CSM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "lost")
    `CSM_ASSERT(a_err_no_data, i_clk, i_rst_n, (o_out_valid && o_out.status != ST_DONE) |-> (o_out.read_value == 64'd0), "data on error")
endmodule
`default_nettype wire

>>> dv/tb_csr_sparse_matvec_top.sv
// testbench for the csr sparse matrix-vector block: directed table, then random traffic
`timescale 1ns / 1ps
module tb_csr_sparse_matvec_top;
    import csm_pkg::*;

    localparam int NumRows = 256;
    localparam int NumCols = 256;
    localparam int StallLimit = 3000;
    localparam int SettleCycles = 300;
    localparam int ItemsPerPhase = 100;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_index = CFG_NUM_ROWS;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out;

    csr_sparse_matvec_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the block state
    logic [63:0] x_vec [NumCols];
    bit          x_written [NumCols];
    logic [63:0] y_vec [NumRows];
    logic [15:0] row_first [NumRows];
    logic [15:0] row_last [NumRows];
    bit          row_loaded [NumRows];
    logic [8:0]  rows_in_domain = 9'd256;
    logic [8:0]  cols_in_domain = 9'd256;

    t_out_item   pending_results [$];
    int          fail_count = 0;
    bit          quiet = 1'b0;
    int          idle_cycles = 0;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_vec_row;
    t_vec_row    directed [$];

    function automatic t_out_item csr_apply(input t_in_item it);
        t_out_item   res;
        bit          found;
        int          row;
        real         prod;
        res = '0;
        found = 1'b0;
        row = 0;
        case (it.operation)
            OP_WRITE_X: begin
                x_vec[it.index] = it.value;
                x_written[it.index] = 1'b1;
            end
            OP_WRITE_RANGE: begin
                row_first[it.index] = it.range_first;
                row_last[it.index] = it.range_last;
                row_loaded[it.index] = 1'b1;
            end
            OP_WRITE_Y: y_vec[it.index] = it.value;
            OP_NONZERO: begin
                for (int r = 0; r < NumRows; r++) begin
                    if (row_loaded[r] && row_first[r] <= it.nz_index
                            && it.nz_index <= row_last[r]) begin
                        found = 1'b1;
                        row = r;
                    end
                end
                if (!found) begin
                    res.status = ST_NO_ROW;
                end else if (it.column < cols_in_domain && it.column < NumCols
                        && row < rows_in_domain) begin
                    // product rounded first, then the sum
                    prod = $bitstoreal(it.value) * $bitstoreal(x_vec[it.column]);
                    y_vec[row] = $realtobits($bitstoreal(y_vec[row]) + prod);
                end else begin
                    res.status = ST_SKIPPED;
                end
            end
            OP_READ_Y: res.read_value = y_vec[it.index];
            default: ;
        endcase
        return res;
    endfunction

    function automatic bit is_nan(input logic [63:0] b);
        return b[62:52] == 11'h7FF && b[51:0] != '0;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] op, input logic [7:0] idx,
                                           input logic [63:0] val, input logic [15:0] rf,
                                           input logic [15:0] rl, input logic [15:0] nz,
                                           input logic [15:0] col);
        t_in_item it;
        it.operation = op;
        it.index = idx;
        it.value = val;
        it.range_first = rf;
        it.range_last = rl;
        it.nz_index = nz;
        it.column = col;
        return it;
    endfunction

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0) return v;
        v[62:52] = 11'(1003 + $urandom_range(0, 40));
        return v;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       pick;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 10) it.operation = OP_WRITE_X;
        else if (pick < 20) it.operation = OP_WRITE_RANGE;
        else if (pick < 28) it.operation = OP_WRITE_Y;
        else if (pick < 83) it.operation = OP_NONZERO;
        else if (pick < 95) it.operation = OP_READ_Y;
        else it.operation = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 7) != 0) it.index = 8'($urandom_range(0, 15));
        it.value = rand_double();
        if ($urandom_range(0, 9) != 0) begin
            it.range_first = 16'($urandom_range(0, 40));
            it.range_last = it.range_first + 16'($urandom_range(0, 15));
            if ($urandom_range(0, 15) == 0) it.range_last = it.range_first - 16'd1;
        end
        if ($urandom_range(0, 9) != 0) it.nz_index = 16'($urandom_range(0, 60));
        if ($urandom_range(0, 9) != 0) it.column = 16'($urandom_range(0, 15));
        // never let a nonzero read an x element that was never loaded
        if (it.column < NumCols && it.column < cols_in_domain && !x_written[it.column])
            it.column = 16'd0;
        return it;
    endfunction

    // one transaction on the input channel; called and returns at a falling edge
    task automatic send(input t_in_item it, input bit typed, input t_out_item want);
        int        gap;
        t_out_item pred;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pred = csr_apply(it);
        pending_results.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [8:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        if (idx == CFG_NUM_ROWS) rows_in_domain = data;
        else cols_in_domain = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic add_row(input t_in_item it, input bit typed, input logic [1:0] st,
                           input logic [63:0] rd);
        t_vec_row row;
        row.item = it;
        row.typed = typed;
        row.want.status = st;
        row.want.read_value = rd;
        directed.push_back(row);
    endtask

    // result checker and receiver stalls
    initial begin
        int        wait_left;
        t_out_item want;
        wait_left = 0;
        forever begin
            @(negedge i_clk);
            i_out_ready = (wait_left == 0);
            if (wait_left > 0) wait_left--;
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                wait_left = quiet ? 0 : $urandom_range(0, 4);
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d value %h",
                             $time, o_out.status, o_out.read_value);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_out.status);
                        fail_count++;
                    end
                    if (o_out.read_value !== want.read_value
                            && !(is_nan(want.read_value) && is_nan(o_out.read_value))) begin
                        $display("%0t: read_value expected %h actual %h",
                                 $time, want.read_value, o_out.read_value);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= StallLimit) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [8:0] phase_rows [5];
        logic [8:0] phase_cols [5];
        phase_rows = '{9'd0, 9'd511, 9'd4, 9'd256, 9'd1};
        phase_cols = '{9'd0, 9'd511, 9'd9, 9'd256, 9'd2};
        for (int r = 0; r < NumRows; r++) begin
            y_vec[r] = '0;
            row_loaded[r] = 1'b0;
        end
        for (int c = 0; c < NumCols; c++) x_written[c] = 1'b0;

        add_row(make_item(OP_READ_Y, 8'd0, '1, '1, '1, '1, '1), 1, ST_DONE, '0);
        add_row(make_item(OP_NONZERO, 8'd0, 64'h3FF0_0000_0000_0000, 0, 0, 0, 0),
                1, ST_NO_ROW, '0);
        add_row(make_item(3'd5, 8'hFF, '1, '1, '1, '1, '1), 1, ST_DONE, '0);
        add_row(make_item(3'd6, 8'd0, '0, '0, '0, '0, '0), 1, ST_DONE, '0);
        add_row(make_item(3'd7, 8'hAA, '1, '0, '1, '0, '1), 1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_X, 8'd0, 64'h4008_0000_0000_0000, 0, 0, 0, 0),
                1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_X, 8'd255, '1, 0, 0, 0, 0), 1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_X, 8'd1, 64'h0000_0000_0000_0001, 0, 0, 0, 0),
                1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_RANGE, 8'd0, 0, 16'd0, 16'hFFFF, 0, 0), 1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_RANGE, 8'd255, 0, 16'd5, 16'd3, 0, 0), 1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_RANGE, 8'd1, 0, 16'd10, 16'd20, 0, 0), 1, ST_DONE, '0);
        add_row(make_item(OP_WRITE_Y, 8'd1, 64'h4000_0000_0000_0000, 0, 0, 0, 0),
                1, ST_DONE, '0);
        // last matching row wins over row zero
        add_row(make_item(OP_NONZERO, 0, 64'h3FF0_0000_0000_0000, 0, 0, 16'd15, 16'd0),
                0, ST_DONE, '0);
        add_row(make_item(OP_READ_Y, 8'd1, 0, 0, 0, 0, 0), 0, ST_DONE, '0);
        add_row(make_item(OP_NONZERO, 0, '1, 0, 0, 16'hFFFF, 16'hFFFF), 1, ST_SKIPPED, '0);
        add_row(make_item(OP_NONZERO, 0, '1, 0, 0, 16'd15, 16'd256), 1, ST_SKIPPED, '0);
        add_row(make_item(OP_NONZERO, 0, 64'h7FEF_FFFF_FFFF_FFFF, 0, 0, 16'd3, 16'd1),
                0, ST_DONE, '0);
        add_row(make_item(OP_READ_Y, 8'd0, 0, 0, 0, 0, 0), 0, ST_DONE, '0);
        add_row(make_item(OP_WRITE_Y, 8'd255, '1, 0, 0, 0, 0), 1, ST_DONE, '0);
        add_row(make_item(OP_READ_Y, 8'd255, 0, 0, 0, 0, 0), 1, ST_DONE, '1);

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[k]) send(directed[k].item, directed[k].typed, directed[k].want);

        for (int p = 0; p < 5; p++) begin
            drain();
            repeat (SettleCycles) @(negedge i_clk);
            write_cfg(CFG_NUM_ROWS, phase_rows[p]);
            write_cfg(CFG_NUM_COLS, phase_cols[p]);
            quiet = (p == 3);
            for (int n = 0; n < ItemsPerPhase; n++) begin
                if (p == 1 && n == ItemsPerPhase / 2) drain();
                send(rand_item(), 1'b0, '0);
            end
        end
        drain();
        repeat (SettleCycles) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/csm_pkg.sv
rtl/csr_sparse_matvec_top.sv
dv/tb_csr_sparse_matvec_top.sv
